>>> rtl/broadcast_tile_address_generator_assert.svh
// Assertion macros used by the tile address generator controller.
`ifndef BROADCAST_TILE_ADDRESS_GENERATOR_ASSERT_SVH
`define BROADCAST_TILE_ADDRESS_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BTA_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define BTA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define BTA_ASSERT_IMPLY(label, ante, cons, msg)
`define BTA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/bta_pkg.sv
// Shared types, constants and helper functions of the tile address generator.
package bta_pkg;

	localparam int DIM_BITS_DEF   = 16;
	localparam int INDEX_BITS_DEF = 32;
	localparam int STRIDE_BITS    = 32;
	localparam int TILE_BITS      = 32;
	localparam int NUM_TENSORS    = 3;
	localparam int NUM_LEVELS     = 6;
	localparam int NUM_STRIDE_REG = 6;
	localparam int CFG_IDX_BITS   = 3;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_SHAPE_OUTER = 3'd0;
	localparam cfg_idx_t CFG_SHAPE_INNER = 3'd1;
	localparam cfg_idx_t CFG_PRED_OUTER  = 3'd2;
	localparam cfg_idx_t CFG_PRED_INNER  = 3'd3;
	localparam cfg_idx_t CFG_TRUE_OUTER  = 3'd4;
	localparam cfg_idx_t CFG_TRUE_INNER  = 3'd5;
	localparam cfg_idx_t CFG_FALSE_OUTER = 3'd6;
	localparam cfg_idx_t CFG_FALSE_INNER = 3'd7;

	typedef logic [2:0] lvl_t;
	localparam lvl_t LVL_OUTER   = 3'd0;
	localparam lvl_t LVL_DEPTH   = 3'd1;
	localparam lvl_t LVL_BATCH   = 3'd2;
	localparam lvl_t LVL_CHANNEL = 3'd3;
	localparam lvl_t LVL_ROW     = 3'd4;
	localparam lvl_t LVL_COLUMN  = 3'd5;

	typedef logic [1:0] ten_t;
	localparam ten_t TEN_FIRST = 2'd0;
	localparam ten_t TEN_LAST  = 2'd2;

	typedef enum logic [3:0] {
		U_HW, U_PN, U_PD, U_PND,
		U_DIV0, U_DIV1, U_DIV2, U_DIV3, U_DIV4,
		U_MAC, U_SHW, U_SMUL
	} uop_t;

	typedef struct packed {
		logic cap;
		logic go;
		logic wb;
		uop_t uop;
		ten_t k;
		lvl_t j;
		lvl_t lvl;
		logic advance;
		logic step;
		logic begin_walk;
		logic deact;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic zero_dim;
		logic found;
		lvl_t lvl;
		logic busy;
		logic done;
		logic out_free;
	} sts_t;

	function automatic int cfg_width(int dim_bits);
		return (3 * dim_bits + 3 > 2 * STRIDE_BITS) ? 3 * dim_bits + 3 : 2 * STRIDE_BITS;
	endfunction

	function automatic int cnt_width(int dim_bits, int index_bits);
		return (dim_bits > index_bits) ? dim_bits : index_bits;
	endfunction

endpackage

>>> rtl/bta_arith.sv
// Bit-serial multiply and restoring divide unit, one bit per cycle, wrapping at INDEX_BITS.
module bta_arith #(
	parameter int INDEX_BITS = bta_pkg::INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic                  div_sel,
	input  logic [INDEX_BITS-1:0] a,
	input  logic [INDEX_BITS-1:0] b,
	output logic                  busy,
	output logic                  done,
	output logic [INDEX_BITS-1:0] res,
	output logic [INDEX_BITS-1:0] rem
);

	localparam int CW = $clog2(INDEX_BITS + 1);

	logic                  busy_q, done_q, div_q;
	logic [CW-1:0]         cnt_q;
	logic [INDEX_BITS-1:0] acc_q, ma_q, mb_q;
	logic [INDEX_BITS:0]   trial, diff;

	always_comb begin
		trial = {acc_q, mb_q[INDEX_BITS-1]};
		diff  = trial - {1'b0, ma_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(INDEX_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			div_q <= div_sel;
			acc_q <= '0;
			ma_q  <= div_sel ? b : a;
			mb_q  <= div_sel ? a : b;
		end else if (busy_q) begin
			if (div_q) begin
				acc_q <= diff[INDEX_BITS] ? trial[INDEX_BITS-1:0] : diff[INDEX_BITS-1:0];
				mb_q  <= {mb_q[INDEX_BITS-2:0], ~diff[INDEX_BITS]};
			end else begin
				acc_q <= acc_q + (mb_q[0] ? ma_q : '0);
				ma_q  <= {ma_q[INDEX_BITS-2:0], 1'b0};
				mb_q  <= {1'b0, mb_q[INDEX_BITS-1:1]};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = div_q ? mb_q : acc_q;
	assign rem  = acc_q;

endmodule

>>> rtl/bta_dp.sv
// Datapath: configuration registers, loop counters, tensor offsets and the result register.
module bta_dp #(
	parameter int DIM_BITS   = bta_pkg::DIM_BITS_DEF,
	parameter int INDEX_BITS = bta_pkg::INDEX_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bta_pkg::cmd_t                         cmd,
	output bta_pkg::sts_t                         sts,
	input  logic                                  cfg_we,
	input  bta_pkg::cfg_idx_t                     cfg_index,
	input  logic [bta_pkg::cfg_width(DIM_BITS)-1:0] cfg_wdata,
	input  logic [31:0]                           first_tile,
	input  logic [31:0]                           tile_budget,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [bta_pkg::TILE_BITS-1:0]         pred_tile,
	output logic [bta_pkg::TILE_BITS-1:0]         true_tile,
	output logic [bta_pkg::TILE_BITS-1:0]         false_tile,
	output logic                                  last_tile
);

	localparam int IW      = INDEX_BITS;
	localparam int CNTW    = bta_pkg::cnt_width(DIM_BITS, INDEX_BITS);
	localparam int SHAPE_W = 3 * DIM_BITS;
	localparam int SW      = bta_pkg::STRIDE_BITS;
	localparam int NT      = bta_pkg::NUM_TENSORS;
	localparam int NL      = bta_pkg::NUM_LEVELS;

	logic [SHAPE_W-1:0]  shape_outer_q;
	logic [SHAPE_W+2:0]  shape_inner_q;
	logic [2*SW-1:0]     strides_q [bta_pkg::NUM_STRIDE_REG];

	logic [CNTW-1:0]     cnt_q [NL];
	logic [IW-1:0]       off_q [NT];
	logic [IW-1:0]       tri_q [NT];
	logic [IW-1:0]       tl_q, hw_q, pn_q, pd_q, pnd_q, rem_q;
	logic                active_q;
	logic [31:0]         first_q, budget_q;
	logic                out_valid_q, last_q;
	logic [bta_pkg::TILE_BITS-1:0] out_q [NT];

	logic [DIM_BITS-1:0] dim [NL];
	logic [NT-1:0]       bc;
	logic [IW-1:0]       str [NT][4];
	logic [IW-1:0]       wt_i, ar_a, ar_b, ar_res, ar_rem, mac_base, mac_term;
	logic                ar_div, ar_busy, ar_done, found, zero_dim;
	bta_pkg::lvl_t       ex_lvl, lvl_m1;

	always_comb begin
		dim[bta_pkg::LVL_OUTER]   = shape_inner_q[DIM_BITS-1:0];
		dim[bta_pkg::LVL_DEPTH]   = shape_outer_q[DIM_BITS-1:0];
		dim[bta_pkg::LVL_BATCH]   = shape_outer_q[2*DIM_BITS-1:DIM_BITS];
		dim[bta_pkg::LVL_CHANNEL] = shape_outer_q[3*DIM_BITS-1:2*DIM_BITS];
		dim[bta_pkg::LVL_ROW]     = shape_inner_q[2*DIM_BITS-1:DIM_BITS];
		dim[bta_pkg::LVL_COLUMN]  = shape_inner_q[3*DIM_BITS-1:2*DIM_BITS];
		bc   = shape_inner_q[SHAPE_W+2:SHAPE_W];
		wt_i = IW'(dim[bta_pkg::LVL_COLUMN]);
		for (int k = 0; k < NT; k++) begin
			str[k][0] = IW'(strides_q[2*k][SW-1:0]);
			str[k][1] = IW'(strides_q[2*k][2*SW-1:SW]);
			str[k][2] = IW'(strides_q[2*k+1][SW-1:0]);
			str[k][3] = IW'(strides_q[2*k+1][2*SW-1:SW]);
		end
	end

	always_comb begin
		found    = 1'b0;
		zero_dim = 1'b0;
		ex_lvl   = bta_pkg::LVL_OUTER;
		for (int e = NL - 1; e >= 0; e--) begin
			if (cnt_q[e] >= CNTW'(dim[e])) begin
				found  = 1'b1;
				ex_lvl = bta_pkg::lvl_t'(e);
			end
			if (dim[e] == '0) begin
				zero_dim = 1'b1;
			end
		end
	end

	assign lvl_m1 = cmd.lvl - bta_pkg::lvl_t'(1);

	always_comb begin
		ar_div = cmd.uop inside {bta_pkg::U_DIV0, bta_pkg::U_DIV1, bta_pkg::U_DIV2,
			bta_pkg::U_DIV3, bta_pkg::U_DIV4};
		case (cmd.uop)
			bta_pkg::U_HW, bta_pkg::U_SHW: begin
				ar_a = IW'(dim[bta_pkg::LVL_ROW]);
				ar_b = wt_i;
			end
			bta_pkg::U_PN: begin
				ar_a = IW'(dim[bta_pkg::LVL_CHANNEL]);
				ar_b = hw_q;
			end
			bta_pkg::U_PD: begin
				ar_a = IW'(dim[bta_pkg::LVL_BATCH]);
				ar_b = pn_q;
			end
			bta_pkg::U_PND: begin
				ar_a = IW'(dim[bta_pkg::LVL_DEPTH]);
				ar_b = pd_q;
			end
			bta_pkg::U_DIV0: begin
				ar_a = IW'(first_q);
				ar_b = pnd_q;
			end
			bta_pkg::U_DIV1: begin
				ar_a = rem_q;
				ar_b = pd_q;
			end
			bta_pkg::U_DIV2: begin
				ar_a = rem_q;
				ar_b = pn_q;
			end
			bta_pkg::U_DIV3: begin
				ar_a = rem_q;
				ar_b = hw_q;
			end
			bta_pkg::U_DIV4: begin
				ar_a = rem_q;
				ar_b = wt_i;
			end
			bta_pkg::U_MAC: begin
				ar_a = IW'(cnt_q[cmd.j]);
				ar_b = (cmd.j == bta_pkg::LVL_ROW) ? wt_i : str[cmd.k][cmd.j[1:0]];
			end
			bta_pkg::U_SMUL: begin
				ar_a = str[cmd.k][cmd.lvl[1:0]];
				ar_b = IW'(dim[cmd.lvl]);
			end
			default: begin
				ar_a = '0;
				ar_b = '0;
			end
		endcase
		mac_base = (cmd.j == bta_pkg::LVL_OUTER) ? '0 : off_q[cmd.k];
		mac_term = (cmd.j == bta_pkg::LVL_ROW && bc[cmd.k]) ? '0 : ar_res;
	end

	bta_arith #(
		.INDEX_BITS(INDEX_BITS)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.go),
		.div_sel(ar_div),
		.a      (ar_a),
		.b      (ar_b),
		.busy   (ar_busy),
		.done   (ar_done),
		.res    (ar_res),
		.rem    (ar_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_outer_q <= '0;
			shape_inner_q <= '0;
			for (int i = 0; i < bta_pkg::NUM_STRIDE_REG; i++) begin
				strides_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				bta_pkg::CFG_SHAPE_OUTER: shape_outer_q <= cfg_wdata[SHAPE_W-1:0];
				bta_pkg::CFG_SHAPE_INNER: shape_inner_q <= cfg_wdata[SHAPE_W+2:0];
				default: strides_q[3'(cfg_index - bta_pkg::CFG_PRED_OUTER)] <= cfg_wdata[2*SW-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < NL; e++) begin
				cnt_q[e] <= '0;
			end
			for (int k = 0; k < NT; k++) begin
				off_q[k] <= '0;
			end
			tl_q     <= '0;
			active_q <= 1'b0;
		end else begin
			if (cmd.wb) begin
				case (cmd.uop)
					bta_pkg::U_DIV0: cnt_q[bta_pkg::LVL_OUTER]   <= CNTW'(ar_res);
					bta_pkg::U_DIV1: cnt_q[bta_pkg::LVL_DEPTH]   <= CNTW'(ar_res);
					bta_pkg::U_DIV2: cnt_q[bta_pkg::LVL_BATCH]   <= CNTW'(ar_res);
					bta_pkg::U_DIV3: cnt_q[bta_pkg::LVL_CHANNEL] <= CNTW'(ar_res);
					bta_pkg::U_DIV4: begin
						cnt_q[bta_pkg::LVL_ROW]    <= CNTW'(ar_res);
						cnt_q[bta_pkg::LVL_COLUMN] <= CNTW'(ar_rem);
					end
					bta_pkg::U_MAC: off_q[cmd.k] <= mac_base + mac_term;
					bta_pkg::U_SHW: begin
						for (int k = 0; k < NT; k++) begin
							off_q[k] <= off_q[k] + str[k][3] - (bc[k] ? '0 : ar_res);
						end
					end
					bta_pkg::U_SMUL: off_q[cmd.k] <= off_q[cmd.k] + str[cmd.k][lvl_m1[1:0]] - ar_res;
					default: ;
				endcase
			end
			if (cmd.advance) begin
				cnt_q[lvl_m1]  <= cnt_q[lvl_m1] + CNTW'(1);
				cnt_q[cmd.lvl] <= '0;
				if (cmd.lvl == bta_pkg::LVL_COLUMN) begin
					for (int k = 0; k < NT; k++) begin
						if (!bc[k]) begin
							off_q[k] <= off_q[k] + wt_i;
						end
					end
				end
			end
			if (cmd.step) begin
				tl_q <= tl_q - IW'(1);
				cnt_q[bta_pkg::LVL_COLUMN] <= cnt_q[bta_pkg::LVL_COLUMN] + CNTW'(1);
				if (tl_q == IW'(1)) begin
					active_q <= 1'b0;
				end
			end
			if (cmd.begin_walk) begin
				tl_q     <= IW'(budget_q);
				active_q <= IW'(budget_q) != '0;
			end
			if (cmd.deact) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			first_q  <= first_tile;
			budget_q <= tile_budget;
		end
		if (cmd.step) begin
			for (int k = 0; k < NT; k++) begin
				tri_q[k] <= off_q[k] + IW'(cnt_q[bta_pkg::LVL_COLUMN]);
			end
		end
		if (cmd.wb) begin
			case (cmd.uop)
				bta_pkg::U_HW:  hw_q  <= ar_res;
				bta_pkg::U_PN:  pn_q  <= ar_res;
				bta_pkg::U_PD:  pd_q  <= ar_res;
				bta_pkg::U_PND: pnd_q <= ar_res;
				default: ;
			endcase
			if (ar_div) begin
				rem_q <= ar_rem;
			end
		end
		if (cmd.load_out) begin
			for (int k = 0; k < NT; k++) begin
				out_q[k] <= bta_pkg::TILE_BITS'(tri_q[k]);
			end
			last_q <= !active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.active   = active_q;
		sts.zero_dim = zero_dim;
		sts.found    = found;
		sts.lvl      = ex_lvl;
		sts.busy     = ar_busy;
		sts.done     = ar_done;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign pred_tile  = out_q[0];
	assign true_tile  = out_q[1];
	assign false_tile = out_q[2];
	assign last_tile  = last_q;

endmodule

>>> rtl/bta_ctrl.sv
// Controller: sequences start set-up, loop settling and result hand-off.
`include "broadcast_tile_address_generator_assert.svh"

module bta_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_opcode,
	output logic          in_ready,
	input  bta_pkg::sts_t sts,
	output bta_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {S_IDLE, S_GO, S_WAIT, S_SETTLE, S_EMIT} state_t;

	state_t          state_q;
	bta_pkg::uop_t   uop_q;
	bta_pkg::ten_t   k_q;
	bta_pkg::lvl_t   j_q, lvl_q;
	logic            step_q;
	logic            accept, settle_end, wait_last;

	assign accept     = in_valid && in_ready;
	assign settle_end = !sts.active || sts.zero_dim || !sts.found
		|| (sts.lvl == bta_pkg::LVL_OUTER);
	assign wait_last  = (uop_q == bta_pkg::U_SHW)
		|| (uop_q == bta_pkg::U_SMUL && k_q == bta_pkg::TEN_LAST)
		|| (uop_q == bta_pkg::U_MAC && k_q == bta_pkg::TEN_LAST
			&& j_q == bta_pkg::LVL_ROW);

	always_comb begin
		cmd        = '0;
		cmd.uop    = uop_q;
		cmd.k      = k_q;
		cmd.j      = j_q;
		cmd.lvl    = (state_q == S_SETTLE) ? sts.lvl : lvl_q;
		in_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					cmd.cap  = 1'b1;
					cmd.step = (in_opcode == bta_pkg::OP_STEP) && sts.active;
				end
			end
			S_GO: cmd.go = 1'b1;
			S_WAIT: begin
				if (sts.done) begin
					cmd.wb = 1'b1;
					cmd.advance = (uop_q == bta_pkg::U_SHW)
						|| (uop_q == bta_pkg::U_SMUL && k_q == bta_pkg::TEN_LAST);
					cmd.begin_walk = uop_q == bta_pkg::U_MAC && k_q == bta_pkg::TEN_LAST
						&& j_q == bta_pkg::LVL_ROW;
				end
			end
			S_SETTLE: begin
				if (settle_end) begin
					cmd.deact = !sts.found || sts.lvl != bta_pkg::LVL_OUTER ? !sts.active
						|| sts.zero_dim : 1'b1;
				end else if (sts.lvl == bta_pkg::LVL_COLUMN) begin
					cmd.advance = 1'b1;
				end
			end
			S_EMIT: cmd.load_out = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			uop_q   <= bta_pkg::U_HW;
			k_q     <= bta_pkg::TEN_FIRST;
			j_q     <= bta_pkg::LVL_OUTER;
			lvl_q   <= bta_pkg::LVL_OUTER;
			step_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q <= in_opcode == bta_pkg::OP_STEP;
						if (in_opcode == bta_pkg::OP_START) begin
							uop_q   <= bta_pkg::U_HW;
							state_q <= S_GO;
						end else if (sts.active) begin
							state_q <= S_SETTLE;
						end
					end
				end
				S_GO: state_q <= S_WAIT;
				S_WAIT: begin
					if (sts.done) begin
						state_q <= wait_last ? S_SETTLE : S_GO;
						case (uop_q)
							bta_pkg::U_HW:   uop_q <= bta_pkg::U_PN;
							bta_pkg::U_PN:   uop_q <= bta_pkg::U_PD;
							bta_pkg::U_PD:   uop_q <= bta_pkg::U_PND;
							bta_pkg::U_PND:  uop_q <= bta_pkg::U_DIV0;
							bta_pkg::U_DIV0: uop_q <= bta_pkg::U_DIV1;
							bta_pkg::U_DIV1: uop_q <= bta_pkg::U_DIV2;
							bta_pkg::U_DIV2: uop_q <= bta_pkg::U_DIV3;
							bta_pkg::U_DIV3: uop_q <= bta_pkg::U_DIV4;
							bta_pkg::U_DIV4: begin
								uop_q <= bta_pkg::U_MAC;
								k_q   <= bta_pkg::TEN_FIRST;
								j_q   <= bta_pkg::LVL_OUTER;
							end
							bta_pkg::U_MAC: begin
								if (j_q == bta_pkg::LVL_ROW) begin
									j_q <= bta_pkg::LVL_OUTER;
									if (k_q != bta_pkg::TEN_LAST) begin
										k_q <= k_q + bta_pkg::ten_t'(1);
									end
								end else begin
									j_q <= j_q + bta_pkg::lvl_t'(1);
								end
							end
							bta_pkg::U_SMUL: begin
								if (k_q != bta_pkg::TEN_LAST) begin
									k_q <= k_q + bta_pkg::ten_t'(1);
								end
							end
							default: ;
						endcase
					end
				end
				S_SETTLE: begin
					if (settle_end) begin
						state_q <= step_q ? S_EMIT : S_IDLE;
					end else if (sts.lvl == bta_pkg::LVL_ROW) begin
						uop_q   <= bta_pkg::U_SHW;
						lvl_q   <= bta_pkg::LVL_ROW;
						state_q <= S_GO;
					end else if (sts.lvl != bta_pkg::LVL_COLUMN) begin
						uop_q   <= bta_pkg::U_SMUL;
						k_q     <= bta_pkg::TEN_FIRST;
						lvl_q   <= sts.lvl;
						state_q <= S_GO;
					end
				end
				S_EMIT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BTA_ASSERT_IMPLY(a_go_idle, cmd.go, !sts.busy, "arithmetic unit started while busy")
	`BTA_ASSERT_NEXT(a_go_busy, cmd.go, sts.busy, "arithmetic unit failed to start")
	`BTA_ASSERT_IMPLY(a_accept_quiet, accept, !sts.busy && !sts.done, "word taken mid-operation")
	`BTA_ASSERT_IMPLY(a_load_free, cmd.load_out, sts.out_free, "result loaded over a waiting word")

endmodule

>>> rtl/broadcast_tile_address_generator.sv
// Top level of the broadcast tile address generator.
//
//  Channel  Direction  Word contents
//  s_axis   in         tuser: opcode; tdata: first_tile [31:0], tile_budget [63:32]
//  m_axis   out        tlast: last_tile; tdata: pred, true, false tile (32 bits each)
//  cfg      in         cfg_we, cfg_index (register 0 to 7), cfg_wdata
//
// A step word that wraps no loop or only the column loop needs no arithmetic; a row
// wrap runs one multiply and a channel, batch or depth wrap runs one per tensor.
// A start word runs a chain of multiplies and divides on the bit-serial
// multiply and divide unit that all products and quotients share.
// Reset is asynchronous and leaves the walk idle with the configuration, counters and offsets at zero.
// A result waiting on m_axis does not stop the next word being taken.
module broadcast_tile_address_generator #(
	parameter int DIM_BITS   = bta_pkg::DIM_BITS_DEF,
	parameter int INDEX_BITS = bta_pkg::INDEX_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [63:0]                           s_axis_tdata,  // first_tile, tile_budget
	input  logic [0:0]                            s_axis_tuser,  // opcode
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [95:0]                           m_axis_tdata,  // pred, true, false tile
	output logic                                  m_axis_tlast,
	input  logic                                  cfg_we,
	input  logic [bta_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [bta_pkg::cfg_width(DIM_BITS)-1:0] cfg_wdata
);

	bta_pkg::cmd_t                 cmd;
	bta_pkg::sts_t                 sts;
	logic [bta_pkg::TILE_BITS-1:0] pred_tile, true_tile, false_tile;

	bta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_opcode(s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bta_dp #(
		.DIM_BITS  (DIM_BITS),
		.INDEX_BITS(INDEX_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.first_tile (s_axis_tdata[31:0]),
		.tile_budget(s_axis_tdata[63:32]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.pred_tile  (pred_tile),
		.true_tile  (true_tile),
		.false_tile (false_tile),
		.last_tile  (m_axis_tlast)
	);

	assign m_axis_tdata = {false_tile, true_tile, pred_tile};

endmodule
